@@ hw/rtl/bvc_pkg.sv @@
// Shared constants, types and table functions for the battery voltage to capacity gauge.
package bvc_pkg;

	localparam int unsigned VOLT_W  = 16;
	localparam int unsigned CAP_W   = 12;
	localparam int unsigned SEG_W   = 4;
	localparam int unsigned DELTA_W = 9;
	localparam int unsigned SPAN_W  = 9;
	localparam int unsigned PROD_W  = 16;
	localparam int unsigned RECIP_W = 12;
	localparam int unsigned RECIP_K = 16;
	localparam int unsigned QUOT_W  = 8;
	localparam int unsigned MULT_W  = PROD_W + RECIP_W;
	localparam int unsigned QD_W    = QUOT_W + SPAN_W;

	localparam int unsigned NUM_POINTS = 11;
	localparam int unsigned NUM_SEGS   = NUM_POINTS - 1;
	localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(NUM_SEGS - 1);

	localparam logic [7:0]       CAP_STEP = 8'd250;
	localparam logic [CAP_W-1:0] CAP_FULL = CAP_W'(2500);
	localparam logic [CAP_W-1:0] CAP_EMPTY = '0;

	localparam logic [VOLT_W-1:0] PT_TOP    = 16'd4170;
	localparam logic [VOLT_W-1:0] PT_BOTTOM = 16'd3200;

	// Per-item control that rides along the pipeline
	typedef struct packed {
		logic             valid;
		logic             above;
		logic             below;
		logic [SEG_W-1:0] seg;
	} tag_t;

	// Voltage table, descending
	function automatic logic [VOLT_W-1:0] point_mv(input logic [SEG_W-1:0] idx);
		logic [VOLT_W-1:0] r;
		case (idx)
			4'd0:    r = 16'd4170;
			4'd1:    r = 16'd4000;
			4'd2:    r = 16'd3880;
			4'd3:    r = 16'd3790;
			4'd4:    r = 16'd3700;
			4'd5:    r = 16'd3660;
			4'd6:    r = 16'd3600;
			4'd7:    r = 16'd3570;
			4'd8:    r = 16'd3520;
			4'd9:    r = 16'd3460;
			4'd10:   r = 16'd3200;
			default: r = 16'd3200;
		endcase
		return r;
	endfunction

	// Width of each segment in mV
	function automatic logic [SPAN_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
		logic [SPAN_W-1:0] r;
		case (seg)
			4'd0:    r = 9'd170;
			4'd1:    r = 9'd120;
			4'd2:    r = 9'd90;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd40;
			4'd5:    r = 9'd60;
			4'd6:    r = 9'd30;
			4'd7:    r = 9'd50;
			4'd8:    r = 9'd60;
			4'd9:    r = 9'd260;
			default: r = 9'd260;
		endcase
		return r;
	endfunction

	// floor(2^RECIP_K / span); the estimate undershoots the true quotient by at most one
	function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
		logic [RECIP_W-1:0] r;
		case (seg)
			4'd0:    r = 12'd385;
			4'd1:    r = 12'd546;
			4'd2:    r = 12'd728;
			4'd3:    r = 12'd728;
			4'd4:    r = 12'd1638;
			4'd5:    r = 12'd1092;
			4'd6:    r = 12'd2184;
			4'd7:    r = 12'd1310;
			4'd8:    r = 12'd1092;
			4'd9:    r = 12'd252;
			default: r = 12'd252;
		endcase
		return r;
	endfunction

	// Capacity at the upper point of a segment: 2500 - 250*seg
	function automatic logic [CAP_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
		logic [CAP_W-1:0] r;
		case (seg)
			4'd0:    r = 12'd2500;
			4'd1:    r = 12'd2250;
			4'd2:    r = 12'd2000;
			4'd3:    r = 12'd1750;
			4'd4:    r = 12'd1500;
			4'd5:    r = 12'd1250;
			4'd6:    r = 12'd1000;
			4'd7:    r = 12'd750;
			4'd8:    r = 12'd500;
			4'd9:    r = 12'd250;
			default: r = 12'd250;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/bvc_seg_find.sv @@
// Stage 1: table compares, segment select and distance from the segment's upper point.
module bvc_seg_find (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [bvc_pkg::VOLT_W-1:0]        voltage_mv,
	output bvc_pkg::tag_t                     tag_s1,
	output logic [bvc_pkg::DELTA_W-1:0]       delta_s1
);

	logic [bvc_pkg::SEG_W-1:0]  seg;
	logic [bvc_pkg::VOLT_W-1:0] diff;
	logic                       above;
	logic                       below;

	always_comb begin
		above = voltage_mv > bvc_pkg::PT_TOP;
		below = voltage_mv < bvc_pkg::PT_BOTTOM;
		// smallest segment whose lower point is at or below the voltage
		seg = bvc_pkg::LAST_SEG;
		for (int i = bvc_pkg::NUM_SEGS - 1; i >= 0; i--) begin
			if (voltage_mv >= bvc_pkg::point_mv(bvc_pkg::SEG_W'(i + 1))) begin
				seg = bvc_pkg::SEG_W'(i);
			end
		end
		diff = bvc_pkg::point_mv(seg) - voltage_mv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.valid <= in_valid;
			tag_s1.above <= above;
			tag_s1.below <= below;
			tag_s1.seg   <= seg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s1 <= diff[bvc_pkg::DELTA_W-1:0];
		end
	end

endmodule

@@ hw/rtl/bvc_const_div.sv @@
// Stages 2 to 4: scale by the step and divide by the segment span through a reciprocal.
module bvc_const_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  bvc_pkg::tag_t                    tag_s1,
	input  logic [bvc_pkg::DELTA_W-1:0]      delta_s1,
	output bvc_pkg::tag_t                    tag_s4,
	output logic [bvc_pkg::PROD_W-1:0]       prod_s4,
	output logic [bvc_pkg::QUOT_W-1:0]       quot_s4,
	output logic [bvc_pkg::QD_W-1:0]         qd_s4
);

	bvc_pkg::tag_t                     tag_s2;
	bvc_pkg::tag_t                     tag_s3;
	logic [bvc_pkg::PROD_W-1:0]        prod_s2;
	logic [bvc_pkg::PROD_W-1:0]        prod_s3;
	logic [bvc_pkg::MULT_W-1:0]        mult_s3;
	logic [bvc_pkg::QUOT_W-1:0]        quot_est;

	assign quot_est = mult_s3[bvc_pkg::RECIP_K +: bvc_pkg::QUOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2      <= bvc_pkg::PROD_W'(delta_s1) * bvc_pkg::PROD_W'(bvc_pkg::CAP_STEP);

			prod_s3      <= prod_s2;
			mult_s3      <= bvc_pkg::MULT_W'(prod_s2) *
			                bvc_pkg::MULT_W'(bvc_pkg::seg_recip(tag_s2.seg));

			prod_s4      <= prod_s3;
			quot_s4      <= quot_est;
			// back-multiply the estimate to find the remainder in the next stage
			qd_s4        <= bvc_pkg::QD_W'(quot_est) *
			                bvc_pkg::QD_W'(bvc_pkg::seg_span(tag_s3.seg));
		end
	end

endmodule

@@ hw/rtl/battery_voltage_to_capacity.sv @@
// Top level: cell voltage in, remaining capacity out, five-stage pipeline.
//
//   channel  signals                         payload
//   in       in_valid / in_ready             voltage_mv [15:0]
//   out      out_valid / out_ready           capacity   [11:0]
//
// One item enters per cycle while the output is not stalled; each result is registered
// in stages 1 to 5 before it is valid at the output. Stage 1 compares against the table,
// stages 2 to 4 scale and divide by the segment span with a reciprocal multiply, stage 5
// corrects the quotient and holds the result. Reset clears the stage tags and the output
// valid, not the data path. A stall at the output freezes every stage at once,
// so in_ready follows out_ready whenever the output register holds a result.
module battery_voltage_to_capacity (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bvc_pkg::VOLT_W-1:0]    voltage_mv,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bvc_pkg::CAP_W-1:0]     capacity
);

	logic                              en;
	bvc_pkg::tag_t                     tag_s1;
	bvc_pkg::tag_t                     tag_s4;
	logic [bvc_pkg::DELTA_W-1:0]       delta_s1;
	logic [bvc_pkg::PROD_W-1:0]        prod_s4;
	logic [bvc_pkg::QUOT_W-1:0]        quot_s4;
	logic [bvc_pkg::QD_W-1:0]          qd_s4;
	logic [bvc_pkg::QD_W-1:0]          rem;
	logic [bvc_pkg::SPAN_W-1:0]        span;
	logic [bvc_pkg::QUOT_W-1:0]        quot;
	logic [bvc_pkg::CAP_W-1:0]         cap_next;
	logic                              valid_s5;
	logic [bvc_pkg::CAP_W-1:0]         cap_s5;

	assign en       = !valid_s5 || out_ready;
	assign in_ready = en;

	bvc_seg_find u_seg_find (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.voltage_mv (voltage_mv),
		.tag_s1     (tag_s1),
		.delta_s1   (delta_s1)
	);

	bvc_const_div u_const_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.tag_s1   (tag_s1),
		.delta_s1 (delta_s1),
		.tag_s4   (tag_s4),
		.prod_s4  (prod_s4),
		.quot_s4  (quot_s4),
		.qd_s4    (qd_s4)
	);

	always_comb begin
		span = bvc_pkg::seg_span(tag_s4.seg);
		rem  = bvc_pkg::QD_W'(prod_s4) - qd_s4;
		// reciprocal estimate is low by at most one
		quot = (rem >= bvc_pkg::QD_W'(span)) ? quot_s4 + 1'b1 : quot_s4;
		if (tag_s4.above) begin
			cap_next = bvc_pkg::CAP_FULL;
		end else if (tag_s4.below) begin
			cap_next = bvc_pkg::CAP_EMPTY;
		end else begin
			cap_next = bvc_pkg::seg_base(tag_s4.seg) - bvc_pkg::CAP_W'(quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= tag_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cap_s5 <= cap_next;
		end
	end

	assign out_valid = valid_s5;
	assign capacity  = cap_s5;

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> capacity <= bvc_pkg::CAP_FULL)
		else $error("capacity above full scale");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s4.valid && !tag_s4.above && !tag_s4.below) |->
		rem < (bvc_pkg::QD_W'(span) << 1))
		else $error("reciprocal estimate off by more than one");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid |-> !(tag_s1.above && tag_s1.below))
		else $error("voltage flagged both above and below the table");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s4.valid && out_valid && !out_ready) |=> $stable(qd_s4) && tag_s4.valid)
		else $error("pipeline advanced during a stall");

endmodule

@@ bench/battery_voltage_to_capacity_test.sv @@
// Self-checking regression bench for the cell voltage to capacity gauge.
module battery_voltage_to_capacity_test;

	localparam int unsigned RANDOM_ITEMS = 1000;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned PRINT_CAP    = 200;

	typedef struct {
		logic [bvc_pkg::VOLT_W-1:0] mv;
		logic [bvc_pkg::CAP_W-1:0]  cap;
	} reading_t;

	class capacity_scoreboard;
		int unsigned knee_mv[bvc_pkg::NUM_POINTS];
		reading_t    pending_readings[$];
		int unsigned mismatches;

		function new();
			knee_mv = '{4170, 4000, 3880, 3790, 3700, 3660, 3600, 3570, 3520, 3460, 3200};
			mismatches = 0;
		endfunction

		// Piecewise-linear lookup, fraction truncated toward zero
		function logic [bvc_pkg::CAP_W-1:0] capacity_for(logic [bvc_pkg::VOLT_W-1:0] mv);
			int unsigned seg;
			int unsigned drop;
			seg = 0;
			if (mv > bvc_pkg::PT_TOP)
				return bvc_pkg::CAP_FULL;
			if (mv < bvc_pkg::PT_BOTTOM)
				return bvc_pkg::CAP_EMPTY;
			// clamp to the last segment so the bottom point stays inside the table
			while (seg < bvc_pkg::NUM_SEGS - 1 && mv < knee_mv[seg + 1])
				seg++;
			drop = (250 * (knee_mv[seg] - mv)) / (knee_mv[seg] - knee_mv[seg + 1]);
			return bvc_pkg::CAP_W'(2500 - 250 * seg - drop);
		endfunction

		function void note_voltage(logic [bvc_pkg::VOLT_W-1:0] mv);
			reading_t r;
			r.mv = mv;
			r.cap = capacity_for(mv);
			pending_readings.push_back(r);
		endfunction

		task report_mismatch(string what);
			if (mismatches < PRINT_CAP)
				$display("capacity mismatch: %s", what);
			mismatches++;
		endtask

		task check_capacity(logic [bvc_pkg::CAP_W-1:0] got);
			reading_t want;
			if (pending_readings.size() == 0) begin
				report_mismatch($sformatf("got %0d with no transfer pending", got));
			end else begin
				want = pending_readings.pop_front();
				if (got !== want.cap)
					report_mismatch($sformatf("voltage %0d mV: got %0d, want %0d",
						want.mv, got, want.cap));
			end
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [bvc_pkg::VOLT_W-1:0] voltage_mv = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [bvc_pkg::CAP_W-1:0]  capacity;

	int unsigned send_idle_pct = 7;
	int unsigned recv_idle_pct = 76;
	int unsigned cycle_count = 0;

	capacity_scoreboard board = new();

	battery_voltage_to_capacity dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.voltage_mv (voltage_mv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.capacity   (capacity)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("battery_voltage_to_capacity regression: fail");
			$finish;
		end
	end

	// Result side: check each transfer out, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_capacity(capacity);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_voltage(input logic [bvc_pkg::VOLT_W-1:0] mv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		voltage_mv <= mv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_voltage(mv);
	endtask

	// Mostly inside the table, some on and around the knees, some in a wider band, the rest anywhere
	function automatic logic [bvc_pkg::VOLT_W-1:0] pick_voltage();
		int unsigned roll;
		int unsigned knee;
		roll = $urandom_range(99);
		knee = board.knee_mv[$urandom_range(bvc_pkg::NUM_POINTS - 1)];
		if (roll < 55)
			return bvc_pkg::VOLT_W'($urandom_range(bvc_pkg::PT_TOP, bvc_pkg::PT_BOTTOM));
		if (roll < 75)
			return bvc_pkg::VOLT_W'(knee + $urandom_range(4) - 2);
		if (roll < 85)
			return bvc_pkg::VOLT_W'($urandom_range(4600, 2800));
		return bvc_pkg::VOLT_W'($urandom);
	endfunction

	initial begin
		logic [bvc_pkg::VOLT_W-1:0] corner_mv[$];
		int unsigned phase;
		corner_mv = '{16'd0, 16'd65535, 16'd4171, 16'd4170, 16'd4169, 16'd4000,
			16'd3880, 16'd3790, 16'd3700, 16'd3660, 16'd3600, 16'd3570, 16'd3520,
			16'd3461, 16'd3460, 16'd3459, 16'd3201, 16'd3200, 16'd3199, 16'd1,
			16'h8000, 16'h7fff, 16'haaaa, 16'h5555};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_mv[i])
			send_voltage(corner_mv[i]);
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 7;
					recv_idle_pct = 76;
				end
				1: begin
					send_idle_pct = 76;
					recv_idle_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_ITEMS / 3)
				send_voltage(pick_voltage());
		end
		in_valid <= 1'b0;
		while (board.pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("battery_voltage_to_capacity regression: pass");
		else
			$display("battery_voltage_to_capacity regression: fail");
		$finish;
	end

endmodule
